>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMP(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NXT(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`endif

>>> rtl/prim_pkg.sv
// ----------------------------------------------------------------------------
// prim_pkg
// Constants, tables and shared types of the 32-bit primality tester.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prim_pkg;

	localparam int unsigned W         = 32;
	localparam int unsigned CNT_W     = 5;
	localparam int unsigned NUM_SMALL = 10;
	localparam int unsigned SP_W      = 5;
	localparam int unsigned NUM_BASES = 3;
	localparam int unsigned BI_W      = 2;
	localparam int unsigned BASE_W    = 6;

	// candidate bits folded into each trial remainder per cycle
	localparam int unsigned        TRIAL_W    = 8;
	localparam logic [CNT_W-1:0]   TRIAL_LAST = CNT_W'(W / TRIAL_W - 1);

	// status of the modular multiplier
	typedef struct packed {
		logic busy;
		logic done;
	} mm_stat_t;

	function automatic logic [SP_W-1:0] small_prime(input logic [3:0] i);
		logic [SP_W-1:0] p;
		case (i)
			4'd0:    p = 5'd2;
			4'd1:    p = 5'd3;
			4'd2:    p = 5'd5;
			4'd3:    p = 5'd7;
			4'd4:    p = 5'd11;
			4'd5:    p = 5'd13;
			4'd6:    p = 5'd17;
			4'd7:    p = 5'd19;
			4'd8:    p = 5'd23;
			4'd9:    p = 5'd29;
			default: p = 5'd2;
		endcase
		return p;
	endfunction

	function automatic logic [BASE_W-1:0] mr_base(input logic [BI_W-1:0] i);
		logic [BASE_W-1:0] b;
		case (i)
			2'd0:    b = 6'd2;
			2'd1:    b = 6'd7;
			2'd2:    b = 6'd61;
			default: b = 6'd2;
		endcase
		return b;
	endfunction

	// base mod n; n >= 31 here so one subtract is enough
	function automatic logic [W-1:0] base_mod(input logic [BI_W-1:0] i,
			input logic [W-1:0] n);
		logic [W-1:0] b;
		b = {{(W-BASE_W){1'b0}}, mr_base(i)};
		return (b >= n) ? (b - n) : b;
	endfunction

endpackage

>>> rtl/prim_mulmod.sv
// ----------------------------------------------------------------------------
// prim_mulmod
// Bit-serial modular multiplier: a*b mod m, one bit of b per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prim_mulmod (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [prim_pkg::W-1:0]  a,
	input  logic [prim_pkg::W-1:0]  b,
	input  logic [prim_pkg::W-1:0]  m,
	output logic [prim_pkg::W-1:0]  result,
	output prim_pkg::mm_stat_t      stat
);

	logic [prim_pkg::W-1:0]     a_q, b_q, m_q, acc_q;
	logic [prim_pkg::CNT_W-1:0] cnt_q;
	logic                       busy_q, done_q;
	logic [prim_pkg::W:0]       t, t2, u, u2, mx;

	// acc < m: 2*acc < 2m, then + a < 2m again
	always_comb begin
		mx = {1'b0, m_q};
		t  = {acc_q, 1'b0};
		t2 = (t >= mx) ? (t - mx) : t;
		u  = t2 + (b_q[prim_pkg::W-1] ? {1'b0, a_q} : '0);
		u2 = (u >= mx) ? (u - mx) : u;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == {prim_pkg::CNT_W{1'b1}}) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			m_q   <= m;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= u2[prim_pkg::W-1:0];
			b_q   <= {b_q[prim_pkg::W-2:0], 1'b0};
		end
	end

	assign result    = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

>>> rtl/primality_test_32bit.sv
// ----------------------------------------------------------------------------
// primality_test_32bit
// Deterministic Miller-Rabin test (bases 2, 7, 61) for 32-bit numbers.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: candidate with req_valid / req_stall. The block takes one
//   request, then holds req_stall high until the answer sits in the output
//   register. Response channel: is_prime with rsp_valid / rsp_stall.
//   Flow: trial division against the primes 2..29 (ten remainder lanes,
//   eight candidate bits per cycle), a decide step, then the load of the
//   output register that raises rsp_valid; inputs settled by the trial
//   division (n < 2 or a small prime factor) end there. Candidates that get
//   past that first split n-1 into d*2^r, then run up to about 61 modular
//   products per base in the shared bit-serial multiplier (start, one step
//   per multiplier bit, done), plus the POW, CHECK and SQR control states.
//   The multiplier is the rate-setting unit.
//   Reset clears the sequencer and the response register; no request is lost
//   or invented. A stalled response holds; a finished answer waits in the
//   sequencer until the output register is free, and a new request is taken
//   the cycle after the previous answer has moved into that register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module primality_test_32bit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  logic [prim_pkg::W-1:0] candidate,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output logic                   is_prime
);

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_TRIAL  = 10'b0000000010,
		ST_SMALL  = 10'b0000000100,
		ST_SHIFT  = 10'b0000001000,
		ST_POW    = 10'b0000010000,
		ST_WAIT_M = 10'b0000100000,
		ST_WAIT_S = 10'b0001000000,
		ST_CHECK  = 10'b0010000000,
		ST_SQR    = 10'b0100000000,
		ST_WAIT_Q = 10'b1000000000
	} state_t;

	// finish state reuses IDLE-adjacent handling via fin_q flag
	state_t                       state_q;
	logic                         fin_q, res_q;
	logic [prim_pkg::W-1:0]       n_q, d_q, e_q, acc_q, pb_q;
	logic [prim_pkg::CNT_W-1:0]   r_q, k_q, cnt_q;
	logic [prim_pkg::BI_W-1:0]    bi_q;
	logic [prim_pkg::SP_W-1:0]    rem_q [prim_pkg::NUM_SMALL];
	logic [prim_pkg::SP_W-1:0]    rem_nx [prim_pkg::NUM_SMALL];
	logic [prim_pkg::SP_W:0]      rem_w;
	logic                         rsp_valid_q, is_prime_q;

	logic [prim_pkg::W-1:0]       nm1, mm_a, mm_b, mm_res;
	logic                         mm_start, load, small_hit, small_eq, sqr_go;
	logic [prim_pkg::BI_W-1:0]    bi_nx;
	prim_pkg::mm_stat_t           mm_stat;

	assign nm1   = n_q - 32'd1;
	assign bi_nx = bi_q + 2'd1;
	assign load  = fin_q && (!rsp_valid_q || !rsp_stall);

	assign req_stall = !(state_q == ST_IDLE) || fin_q;

	// squaring loop of the strong test: k+1 < r and x != n-1
	assign sqr_go = (({1'b0, k_q} + 6'd1) < {1'b0, r_q}) && (acc_q != nm1);

	// trial remainders: fold the top TRIAL_W bits of n, MSB first,
	// one compare-and-subtract per bit
	always_comb begin
		rem_w = '0;
		for (int i = 0; i < prim_pkg::NUM_SMALL; i++) begin
			rem_nx[i] = rem_q[i];
			for (int j = 0; j < prim_pkg::TRIAL_W; j++) begin
				rem_w = {rem_nx[i], n_q[prim_pkg::W-1-j]};
				if (rem_w >= {1'b0, prim_pkg::small_prime(4'(i))})
					rem_nx[i] = 5'(rem_w - {1'b0, prim_pkg::small_prime(4'(i))});
				else
					rem_nx[i] = rem_w[prim_pkg::SP_W-1:0];
			end
		end
	end

	// first small prime that divides n decides
	always_comb begin
		small_hit = 1'b0;
		small_eq  = 1'b0;
		for (int i = prim_pkg::NUM_SMALL - 1; i >= 0; i--) begin
			if (rem_q[i] == '0) begin
				small_hit = 1'b1;
				small_eq  = (n_q == {{(prim_pkg::W-prim_pkg::SP_W){1'b0}},
					prim_pkg::small_prime(4'(i))});
			end
		end
	end

	always_comb begin
		mm_start = 1'b0;
		mm_a     = pb_q;
		mm_b     = pb_q;
		case (state_q)
			ST_POW: begin
				mm_start = !fin_q && (e_q != '0);
				mm_a     = e_q[0] ? acc_q : pb_q;
			end
			ST_SQR: begin
				mm_start = !fin_q && sqr_go;
				mm_a     = acc_q;
				mm_b     = acc_q;
			end
			default: begin
				mm_start = 1'b0;
			end
		endcase
	end

	prim_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.a      (mm_a),
		.b      (mm_b),
		.m      (n_q),
		.result (mm_res),
		.stat   (mm_stat)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fin_q   <= 1'b0;
		end else if (fin_q) begin
			if (load) begin
				fin_q   <= 1'b0;
				state_q <= ST_IDLE;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) state_q <= ST_TRIAL;
				end
				ST_TRIAL: begin
					if (cnt_q == prim_pkg::TRIAL_LAST) state_q <= ST_SMALL;
				end
				ST_SMALL: begin
					if (n_q < 32'd2 || small_hit) fin_q <= 1'b1;
					else state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					if (d_q[0]) state_q <= ST_POW;
				end
				ST_POW: begin
					if (e_q == '0) state_q <= ST_CHECK;
					else if (e_q[0]) state_q <= ST_WAIT_M;
					else state_q <= ST_WAIT_S;
				end
				ST_WAIT_M: begin
					if (mm_stat.done) state_q <= ST_POW;
				end
				ST_WAIT_S: begin
					if (mm_stat.done) state_q <= ST_POW;
				end
				ST_CHECK: begin
					if (acc_q <= 32'd1 || acc_q == nm1) begin
						if (bi_q == 2'd2) fin_q <= 1'b1;
						else state_q <= ST_POW;
					end else begin
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					if (sqr_go) state_q <= ST_WAIT_Q;
					else if (acc_q != nm1 || bi_q == 2'd2) fin_q <= 1'b1;
					else state_q <= ST_POW;
				end
				ST_WAIT_Q: begin
					if (mm_stat.done) state_q <= ST_SQR;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (!fin_q) begin
			case (state_q)
				ST_IDLE: begin
					n_q   <= candidate;
					cnt_q <= '0;
					for (int i = 0; i < prim_pkg::NUM_SMALL; i++) rem_q[i] <= '0;
				end
				ST_TRIAL: begin
					cnt_q <= cnt_q + 1'b1;
					// rotate so n is whole again after the last step
					n_q   <= {n_q[prim_pkg::W-prim_pkg::TRIAL_W-1:0],
						n_q[prim_pkg::W-1 -: prim_pkg::TRIAL_W]};
					for (int i = 0; i < prim_pkg::NUM_SMALL; i++) rem_q[i] <= rem_nx[i];
				end
				ST_SMALL: begin
					res_q <= (n_q >= 32'd2) && small_eq;
					d_q   <= nm1;
					r_q   <= '0;
				end
				ST_SHIFT: begin
					if (!d_q[0]) begin
						d_q <= {1'b0, d_q[prim_pkg::W-1:1]};
						r_q <= r_q + 1'b1;
					end else begin
						bi_q  <= '0;
						e_q   <= d_q;
						acc_q <= 32'd1;
						pb_q  <= prim_pkg::base_mod(2'd0, n_q);
					end
				end
				ST_POW: begin
					k_q <= '0;
				end
				ST_WAIT_M: begin
					if (mm_stat.done) begin
						acc_q  <= mm_res;
						e_q[0] <= 1'b0;
					end
				end
				ST_WAIT_S: begin
					if (mm_stat.done) begin
						pb_q <= mm_res;
						e_q  <= {1'b0, e_q[prim_pkg::W-1:1]};
					end
				end
				ST_CHECK: begin
					if (acc_q <= 32'd1 || acc_q == nm1) begin
						res_q <= 1'b1;
						bi_q  <= bi_nx;
						e_q   <= d_q;
						acc_q <= 32'd1;
						pb_q  <= prim_pkg::base_mod(bi_nx, n_q);
					end
				end
				ST_SQR: begin
					if (!sqr_go) begin
						res_q <= (acc_q == nm1);
						bi_q  <= bi_nx;
						e_q   <= d_q;
						acc_q <= 32'd1;
						pb_q  <= prim_pkg::base_mod(bi_nx, n_q);
					end
				end
				ST_WAIT_Q: begin
					if (mm_stat.done) begin
						acc_q <= mm_res;
						k_q   <= k_q + 1'b1;
					end
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) is_prime_q <= res_q;
	end

	assign rsp_valid = rsp_valid_q;
	assign is_prime  = is_prime_q;

	// checks
	`ASSERT_IMP(a_mm_start_idle, mm_start, !mm_stat.busy)
	`ASSERT_IMP(a_mm_done_waiting, mm_stat.done && !fin_q,
		state_q == ST_WAIT_M || state_q == ST_WAIT_S || state_q == ST_WAIT_Q)
	`ASSERT_NXT(a_even_not_prime, load && !n_q[0] && n_q != 32'd2 && state_q == ST_SMALL,
		!is_prime)

endmodule
